// ===== design/salru_pkg.sv =====
// Shared types, codes and constants of the set-associative LRU cache model.
package salru_pkg;

  localparam int IN_ADDR_W    = 64;
  localparam int CNT_W        = 32;
  localparam int WAY_IDX_W    = 3;
  localparam int REQ_W        = 2;
  localparam int OUTCOME_W    = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 6;
  localparam int SET_BITS_W   = 4;
  localparam int OFF_BITS_W   = 6;
  localparam int WAYS_W       = 4;
  localparam int OFF_BITS_MAX = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 4'd4;
  localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_FETCH  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_STORE  = 2'd2,
    REQ_MODIFY = 2'd3
  } req_type_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [SET_BITS_W-1:0] set_bits;
    logic [OFF_BITS_W-1:0] off_bits;
    logic [WAYS_W-1:0]     ways;
  } cfg_t;

  typedef logic [CNT_W-1:0] cnt_t;

  // Counter increment that sticks at all ones.
  function automatic cnt_t sat_inc(input cnt_t c);
    sat_inc = (c == '1) ? c : c + 1'b1;
  endfunction

endpackage

// ===== design/salru_if.sv =====
// Handshake channel interfaces for trace words in and result words out.
interface salru_in_if;
  import salru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [IN_ADDR_W-1:0] address;

  modport source (output valid, output req_type, output address, input ready);
  modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface salru_out_if;
  import salru_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [WAY_IDX_W-1:0] way_index;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;
  logic [CNT_W-1:0]     eviction_count;
  logic                 last;

  modport source (output valid, output outcome, output way_index, output hit_count,
                  output miss_count, output eviction_count, output last, input ready);
  modport sink   (input valid, input outcome, input way_index, input hit_count,
                  input miss_count, input eviction_count, input last, output ready);
endinterface

// ===== design/salru_front.sv =====
// Front end: accepts trace words, drops fetches and splits the address into set and tag.
module salru_front #(
  parameter int MAX_SET_BITS = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  salru_pkg::cfg_t                      cfg,
  input  logic                                 enable,
  salru_in_if.sink                             in_ch,
  output logic                                 job_valid,
  output logic [MAX_SET_BITS+ADDR_WIDTH-2:0]   job_data,
  input  logic                                 job_ready
);
  import salru_pkg::*;

  localparam int TAG_W = ADDR_WIDTH - 2;
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W  = 7;

  typedef struct packed {
    logic                    modify;
    logic [MAX_SET_BITS-1:0] set;
    logic [TAG_W-1:0]        tag;
  } job_t;

  job_t                    job;
  logic [SB_W-1:0]         s_cl;
  logic [OFF_BITS_W-1:0]   b_cl;
  logic [SH_W-1:0]         tag_sh;
  logic [ADDR_WIDTH-1:0]   addr_a;
  logic [ADDR_WIDTH-1:0]   tag_full;
  logic [ADDR_WIDTH-1:0]   set_full;
  logic [MAX_SET_BITS-1:0] set_mask;

  // Out-of-range field widths are pulled back to their legal bounds.
  always_comb begin
    if (cfg.set_bits == '0) begin
      s_cl = SB_W'(1);
    end else if (int'(cfg.set_bits) > MAX_SET_BITS) begin
      s_cl = SB_W'(MAX_SET_BITS);
    end else begin
      s_cl = SB_W'(cfg.set_bits);
    end
    if (cfg.off_bits == '0) begin
      b_cl = OFF_BITS_W'(1);
    end else if (int'(cfg.off_bits) > OFF_BITS_MAX) begin
      b_cl = OFF_BITS_W'(OFF_BITS_MAX);
    end else begin
      b_cl = cfg.off_bits;
    end
  end

  assign addr_a   = in_ch.address[ADDR_WIDTH-1:0];
  assign tag_sh   = SH_W'(s_cl) + SH_W'(b_cl);
  assign tag_full = addr_a >> tag_sh;
  assign set_full = addr_a >> b_cl;
  assign set_mask = ~({MAX_SET_BITS{1'b1}} << s_cl);

  assign job.modify = (in_ch.req_type == REQ_MODIFY);
  assign job.set    = set_full[MAX_SET_BITS-1:0] & set_mask;
  assign job.tag    = tag_full[TAG_W-1:0];
  assign job_data   = job;

  // Fetch words are taken and dropped; everything else becomes a job.
  assign in_ch.ready = enable && job_ready;
  assign job_valid   = in_ch.valid && enable && (in_ch.req_type != REQ_FETCH);

endmodule

// ===== design/salru_queue.sv =====
// Two-entry job queue between the front end and the lookup engine.
module salru_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data,
  input  logic             pop_ready
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             push, pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/salru_back.sv =====
// Lookup engine: set store, hit and victim selection, LRU update and result register.
module salru_back #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  salru_pkg::cfg_t                      cfg,
  input  logic                                 job_valid,
  input  logic [MAX_SET_BITS+ADDR_WIDTH-2:0]   job_data,
  output logic                                 job_ready,
  output logic                                 clear_busy,
  salru_out_if.source                          out_ch
);
  import salru_pkg::*;

  localparam int TAG_W     = ADDR_WIDTH - 2;
  localparam int SET_DEPTH = 1 << MAX_SET_BITS;
  localparam int RANK_W    = $clog2(MAX_WAYS + 1);
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef struct packed {
    logic                    modify;
    logic [MAX_SET_BITS-1:0] set;
    logic [TAG_W-1:0]        tag;
  } job_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]             valid;
    logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
  } row_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [MAX_SET_BITS-1:0] clr_idx_r, clr_idx_nxt;
  logic                    pass_r, pass_nxt;
  job_t                    job_r;
  job_t                    job_in;

  row_t                    mem [SET_DEPTH];
  row_t                    row_r;
  logic                    rd_en;
  logic                    mem_we;
  logic [MAX_SET_BITS-1:0] mem_wa;
  row_t                    mem_wd;

  cnt_t                    hit_cnt_r, hit_cnt_nxt;
  cnt_t                    miss_cnt_r, miss_cnt_nxt;
  cnt_t                    evict_cnt_r, evict_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUTCOME_W-1:0]    out_outcome_r;
  logic [WAY_IDX_W-1:0]    out_way_r;
  logic                    out_last_r;
  logic                    go;
  logic                    load_out;
  logic                    first_of_two;

  logic [RANK_W-1:0]       n_ways;
  logic [MAX_WAYS-1:0]     in_use;
  logic [MAX_WAYS-1:0]     hit_vec;
  logic [MAX_WAYS-1:0]     empty_vec;
  logic                    hit;
  logic                    empty;
  logic [WAY_W-1:0]        hit_way;
  logic [WAY_W-1:0]        empty_way;
  logic [WAY_W-1:0]        vict_way;
  logic [WAY_W-1:0]        way;
  logic [RANK_W-1:0]       best_rank;
  logic [RANK_W-1:0]       cur_rank;
  logic                    found;
  row_t                    new_row;
  outcome_t                outcome;

  assign job_in       = job_data;
  assign first_of_two = job_r.modify && !pass_r;

  // Lookup on the row held in row_r: hit search, first empty way, LRU victim,
  // then the rank update that makes the chosen way most recent.
  always_comb begin
    if (cfg.ways == '0) begin
      n_ways = RANK_W'(1);
    end else if (int'(cfg.ways) > MAX_WAYS) begin
      n_ways = RANK_W'(MAX_WAYS);
    end else begin
      n_ways = RANK_W'(cfg.ways);
    end

    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]    = RANK_W'(w) < n_ways;
      hit_vec[w]   = in_use[w] && row_r.valid[w] && (row_r.tag[w] == job_r.tag);
      empty_vec[w] = in_use[w] && !row_r.valid[w];
    end

    hit_way   = '0;
    empty_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (empty_vec[w]) begin
        empty_way = WAY_W'(w);
      end
    end

    // Smallest rank wins; a strict compare keeps the lowest way on a tie.
    vict_way  = '0;
    best_rank = '0;
    found     = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (!found || row_r.rank[w] < best_rank)) begin
        best_rank = row_r.rank[w];
        vict_way  = WAY_W'(w);
        found     = 1'b1;
      end
    end

    hit   = |hit_vec;
    empty = |empty_vec;
    if (hit) begin
      way     = hit_way;
      outcome = OUT_HIT;
    end else if (empty) begin
      way     = empty_way;
      outcome = OUT_FILL;
    end else begin
      way     = vict_way;
      outcome = OUT_EVICT;
    end

    cur_rank = row_r.rank[way];
    new_row  = row_r;
    if (!hit) begin
      new_row.tag[way]   = job_r.tag;
      new_row.valid[way] = 1'b1;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && new_row.valid[w] && row_r.rank[w] > cur_rank) begin
        new_row.rank[w] = row_r.rank[w] - 1'b1;
      end
    end
    new_row.rank[way] = n_ways;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    pass_nxt      = pass_r;
    job_ready     = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = job_r.set;
    mem_wd        = new_row;
    load_out      = 1'b0;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    go            = !out_valid_r || out_ch.ready;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_r;
        mem_wd = '0;
        if (clr_idx_r == '1) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          rd_en     = 1'b1;
          pass_nxt  = 1'b0;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (go) begin
          mem_we        = 1'b1;
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          if (hit) begin
            hit_cnt_nxt = sat_inc(hit_cnt_r);
          end else begin
            miss_cnt_nxt = sat_inc(miss_cnt_r);
          end
          if (!hit && !empty) begin
            evict_cnt_nxt = sat_inc(evict_cnt_r);
          end
          if (first_of_two) begin
            pass_nxt = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      pass_r      <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      pass_r      <= pass_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      job_r <= job_in;
    end
    if (load_out) begin
      out_outcome_r <= outcome;
      out_way_r     <= WAY_IDX_W'(way);
      out_last_r    <= !first_of_two;
    end
  end

  // One row per set; the second lookup of a modify reuses the updated row.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      row_r <= mem[job_in.set];
    end else if (load_out && first_of_two) begin
      row_r <= new_row;
    end
  end

  assign clear_busy            = (state_r == ST_CLEAR);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = out_outcome_r;
  assign out_ch.way_index      = out_way_r;
  assign out_ch.hit_count      = hit_cnt_r;
  assign out_ch.miss_count     = miss_cnt_r;
  assign out_ch.eviction_count = evict_cnt_r;
  assign out_ch.last           = out_last_r;

endmodule

// ===== design/set_assoc_lru_cache_model_unit.sv =====
// Top level of the set-associative cache model with true LRU replacement.
//
//   Channel  Direction  Word contents
//   in_ch    in         req_type, address
//   out_ch   out        outcome, way_index, hit_count, miss_count, eviction_count, last
//   cfg_*    in         cfg_we, cfg_index, cfg_data (set bits, offset bits, ways in use)
//
// In the lookup engine a load or store is a row read, then a lookup and write-back; a
// modify does the lookup and write-back once more on the updated row. A fetch word is
// taken and leaves no trace. After reset the engine clears the set store, one set per
// cycle, all 2**MAX_SET_BITS sets (256 with the default), and in_ch.ready stays low
// until that is done.
// A two-word job queue lets the front keep taking words while the engine waits on a
// result word that out_ch has not yet taken.
module set_assoc_lru_cache_model_unit #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int ADDR_WIDTH   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0] cfg_data,
  salru_in_if.sink                         in_ch,
  salru_out_if.source                      out_ch
);
  import salru_pkg::*;

  // A job is the modify flag, the set index and the tag.
  localparam int JOB_W = 1 + MAX_SET_BITS + ADDR_WIDTH - 2;

  logic [SET_BITS_W-1:0] set_bits_r;
  logic [OFF_BITS_W-1:0] off_bits_r;
  logic [WAYS_W-1:0]     ways_r;
  cfg_t                  cfg;

  logic             fr_valid;
  logic [JOB_W-1:0] fr_data;
  logic             fr_ready;
  logic             bk_valid;
  logic [JOB_W-1:0] bk_data;
  logic             bk_ready;
  logic             clear_busy;

  // Configuration registers hold the raw written values; users clamp them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r <= SET_BITS_RST;
      off_bits_r <= OFF_BITS_RST;
      ways_r     <= WAYS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SET_BITS: set_bits_r <= cfg_data[SET_BITS_W-1:0];
        CFG_OFF_BITS: off_bits_r <= cfg_data[OFF_BITS_W-1:0];
        CFG_WAYS:     ways_r     <= cfg_data[WAYS_W-1:0];
        default:      ;
      endcase
    end
  end

  assign cfg.set_bits = set_bits_r;
  assign cfg.off_bits = off_bits_r;
  assign cfg.ways     = ways_r;

  salru_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_front (
    .cfg       (cfg),
    .enable    (!clear_busy),
    .in_ch     (in_ch),
    .job_valid (fr_valid),
    .job_data  (fr_data),
    .job_ready (fr_ready)
  );

  salru_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_data  (fr_data),
    .push_ready (fr_ready),
    .pop_valid  (bk_valid),
    .pop_data   (bk_data),
    .pop_ready  (bk_ready)
  );

  salru_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .job_valid  (bk_valid),
    .job_data   (bk_data),
    .job_ready  (bk_ready),
    .clear_busy (clear_busy),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  // A hit word always carries a hit count that has moved off zero.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.outcome == OUT_HIT |-> out_ch.hit_count != '0)
    else $error("hit reported with zero hit count");

  // An eviction is also a miss, so both counts are past zero.
  a_evict_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.outcome == OUT_EVICT |->
      out_ch.miss_count != '0 && out_ch.eviction_count != '0)
    else $error("eviction reported with zero miss or eviction count");

  // The store half of a modify finds the line that the load half hit or just brought in.
  a_modify_second_hits: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && !out_ch.last |=>
      !out_ch.valid || (out_ch.outcome == OUT_HIT && out_ch.last))
    else $error("second word of a modify is not a final hit");
`endif

endmodule
